[design/ggvc_pkg.sv]
package ggvc_pkg;

   // configuration register indexes
   localparam logic [1:0] REG_GOAL_X    = 2'd0;
   localparam logic [1:0] REG_GOAL_Y    = 2'd1;
   localparam logic [1:0] REG_CRUISE    = 2'd2;
   localparam logic [1:0] REG_ARRIVE_TOL = 2'd3;

   localparam int POS_W   = 16;
   localparam int ANG_W   = 16;
   localparam int SPD_W   = 12;
   localparam int TOL_W   = 15;
   localparam int DELTA_W = 17;
   localparam int DSQ_W   = 33;
   localparam int NEAR_W  = 20;
   localparam int ROOT_W  = 10;
   localparam int MUL_W   = 21;
   localparam int PROD_W  = 2 * MUL_W;

   // CORDIC datapath
   localparam int CRD_XY_W = 28;
   localparam int CRD_Z_W  = 20;
   localparam int CRD_STEPS = 16;
   localparam int CRD_CNT_W = 4;
   localparam logic signed [CRD_Z_W-1:0] PI_Q16 = 20'sd205887;

   localparam logic [DSQ_W-1:0] NEAR_DSQ  = 33'd589824;   // 3 m squared, Q.16
   localparam logic [SPD_W-1:0] MIN_SPEED = 12'd26;       // 0.1 m/s

   // reciprocal multipliers for divide by constant
   localparam logic [MUL_W-1:0] RECIP3  = 21'd43691;     // >> 17
   localparam logic [MUL_W-1:0] RECIP5  = 21'd419431;    // >> 21
   localparam logic [MUL_W-1:0] RECIP10 = 21'd1677722;   // >> 24

   localparam logic [NEAR_W:0] ISQRT_TOP_BIT = 21'h40000;

   function automatic logic signed [CRD_Z_W-1:0] atan_q16(input logic [CRD_CNT_W-1:0] i);
      logic signed [CRD_Z_W-1:0] a;
      unique case (i)
         4'd0:  a = 20'sd51472;
         4'd1:  a = 20'sd30386;
         4'd2:  a = 20'sd16055;
         4'd3:  a = 20'sd8150;
         4'd4:  a = 20'sd4091;
         4'd5:  a = 20'sd2047;
         4'd6:  a = 20'sd1024;
         4'd7:  a = 20'sd512;
         4'd8:  a = 20'sd256;
         4'd9:  a = 20'sd128;
         4'd10: a = 20'sd64;
         4'd11: a = 20'sd32;
         4'd12: a = 20'sd16;
         4'd13: a = 20'sd8;
         4'd14: a = 20'sd4;
         4'd15: a = 20'sd2;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

[design/ggvc_isqrt.sv]
module ggvc_isqrt import ggvc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NEAR_W-1:0] radicand,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   logic [NEAR_W-1:0] rem_ff, rem_in;
   logic [NEAR_W:0]   root_ff, root_in;
   logic [NEAR_W:0]   bit_ff, bit_in;
   logic [NEAR_W:0]   trial;
   logic              run_ff, run_in;
   logic              done_ff, done_in;

   // one result bit per cycle
   always_comb begin
      trial   = root_ff + bit_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      run_in  = run_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = radicand;
         root_in = '0;
         bit_in  = ISQRT_TOP_BIT;
         run_in  = 1'b1;
         done_in = 1'b0;
      end else if (run_ff) begin
         if ({1'b0, rem_ff} >= trial) begin
            rem_in  = rem_ff - trial[NEAR_W-1:0];
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
   end

   assign done = done_ff;
   assign root = root_ff[ROOT_W-1:0];

endmodule

[design/ggvc_cordic.sv]
module ggvc_cordic import ggvc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [DELTA_W-1:0] dx,
   input  logic signed [DELTA_W-1:0] dy,
   output logic                      done,
   output logic signed [ANG_W-1:0]   bearing
);

   logic signed [CRD_XY_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [CRD_XY_W-1:0] xs, ys, dxe, dye;
   logic signed [CRD_Z_W-1:0]  z_ff, z_in, at;
   logic [CRD_CNT_W-1:0]       step_ff, step_in;
   logic                       run_ff, run_in, done_ff, done_in;
   logic                       zero_ff, zero_in;
   logic [CRD_Z_W:0]           z_mag;
   logic [CRD_Z_W:0]           z_rnd;

   always_comb begin
      dxe     = CRD_XY_W'(dx) <<< 8;
      dye     = CRD_XY_W'(dy) <<< 8;
      xs      = x_ff >>> step_ff;
      ys      = y_ff >>> step_ff;
      at      = atan_q16(step_ff);
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = done_ff;
      zero_in = zero_ff;
      if (start) begin
         zero_in = (dx == '0) && (dy == '0);
         step_in = '0;
         run_in  = 1'b1;
         done_in = 1'b0;
         if (dx[DELTA_W-1]) begin
            x_in = -dxe;
            y_in = -dye;
            z_in = dy[DELTA_W-1] ? -PI_Q16 : PI_Q16;
         end else begin
            x_in = dxe;
            y_in = dye;
            z_in = '0;
         end
      end else if (run_ff) begin
         if (!y_ff[CRD_XY_W-1]) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end
         step_in = step_ff + 1'b1;
         if (step_ff == CRD_CNT_W'(CRD_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      step_ff <= step_in;
      zero_ff <= zero_in;
   end

   // Q.16 to Q.12, half away from zero
   always_comb begin
      z_mag = z_ff[CRD_Z_W-1] ? -(CRD_Z_W+1)'(z_ff) : (CRD_Z_W+1)'(z_ff);
      z_rnd = (z_mag + (CRD_Z_W+1)'(8)) >> 4;
      if (zero_ff)
         bearing = '0;
      else if (z_ff[CRD_Z_W-1])
         bearing = -$signed(z_rnd[ANG_W-1:0]);
      else
         bearing = $signed(z_rnd[ANG_W-1:0]);
   end

   assign done = done_ff;

endmodule

[design/go_to_goal_velocity_controller_core.sv]
// Go-to-goal velocity controller.
// req channel: one transaction per control tick carrying the robot pose and the
// measured speed. rsp channel: the velocity command for that tick; when the
// goal lies within the arrival tolerance a second transaction follows with a
// zero command and tlast high, and the running heading state is cleared.
// csr port: goal position, cruise speed and arrival tolerance, written while
// the block is idle; this binds the user, the block does not enforce it.
// No new request is taken while a tick is in progress: req_tready returns in
// the same cycle that the command appears on rsp, or on arrival in the cycle
// after the first command leaves. The tick time is set by the 16 iterations
// of the vectoring CORDIC for the bearing; the distance square root runs
// alongside it, and a single shared multiplier does the squares, the
// root-times-cruise product and the constant divisions in turn.
// Reset restores the register defaults and clears the running state; no
// clearing pass is needed. A stalled receiver holds the result register, and
// the sequencer waits at its output step until the register is free.
module go_to_goal_velocity_controller_core import ggvc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // pos_x, pos_y, heading, measured_speed
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // linear_cmd, angular_cmd
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SQX  = 4'd1;
   localparam logic [3:0] S_SQY  = 4'd2;
   localparam logic [3:0] S_TOL  = 4'd3;
   localparam logic [3:0] S_CMP  = 4'd4;
   localparam logic [3:0] S_AVG  = 4'd5;
   localparam logic [3:0] S_DIF  = 4'd6;
   localparam logic [3:0] S_DIFW = 4'd7;
   localparam logic [3:0] S_SQRT = 4'd8;
   localparam logic [3:0] S_V1   = 4'd9;
   localparam logic [3:0] S_V2   = 4'd10;
   localparam logic [3:0] S_CORW = 4'd11;
   localparam logic [3:0] S_OUT1 = 4'd12;
   localparam logic [3:0] S_OUT2 = 4'd13;

   logic [3:0] state_ff, state_in;

   // configuration
   logic signed [POS_W-1:0] goal_x_ff, goal_y_ff;
   logic [SPD_W-1:0]        cruise_ff;
   logic [TOL_W-1:0]        tol_ff;

   // running state
   logic signed [ANG_W-1:0] prev_ang_ff, prev_ang_in;
   logic signed [17:0]      avg_ff, avg_in;
   logic                    first_ff, first_in;

   // per-tick working registers
   logic signed [DELTA_W-1:0] dx_ff, dx_in, dy_ff, dy_in, diff_ff, diff_in;
   logic signed [ANG_W-1:0]   hd_ff, hd_in;
   logic [SPD_W-1:0]          meas_ff, meas_in;
   logic signed [17:0]        avg0_ff, avg0_in, avg_new_ff, avg_new_in;
   logic [DSQ_W-1:0]          dsq_ff, dsq_in;
   logic                      far_ff, far_in, arrive_ff, arrive_in;
   logic                      neg_ff, neg_in;
   logic signed [16:0]        t5_ff, t5_in;
   logic [SPD_W-1:0]          lin_ff, lin_in;
   logic signed [ANG_W-1:0]   ang_ff, ang_in;
   logic [PROD_W-1:0]         prod_ff;
   logic [MUL_W-1:0]          mul_a, mul_b;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SPD_W-1:0]     rsp_lin_ff, rsp_lin_in;
   logic [ANG_W-1:0]     rsp_ang_ff, rsp_ang_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                      accept;
   logic                      out_free;
   logic                      crd_start, crd_done, sq_start, sq_done;
   logic signed [ANG_W-1:0]   bearing;
   logic [ROOT_W-1:0]         root;
   logic [DELTA_W-1:0]        dx_mag, dy_mag;
   logic signed [21:0]        num;
   logic [21:0]               num_mag;
   logic [19:0]               diff_mag, avg_mag;
   logic signed [19:0]        n5;
   logic [19:0]               n5_mag;
   logic [SPD_W-1:0]          v_near, lin_sel;
   logic signed [18:0]        ang_sum;
   logic signed [POS_W-1:0]   req_pos_x, req_pos_y, req_heading;

   assign req_pos_x   = $signed(req_tdata[15:0]);
   assign req_pos_y   = $signed(req_tdata[31:16]);
   assign req_heading = $signed(req_tdata[47:32]);

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign crd_start  = (state_ff == S_SQX);
   assign sq_start   = (state_ff == S_CMP);

   ggvc_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (crd_start),
      .dx      (dx_ff),
      .dy      (dy_ff),
      .done    (crd_done),
      .bearing (bearing)
   );

   ggvc_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (dsq_ff[NEAR_W-1:0]),
      .done     (sq_done),
      .root     (root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff <= 16'sd256;
         goal_y_ff <= 16'sd256;
         cruise_ff <= 12'd256;
         tol_ff    <= 15'd3;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_GOAL_X:     goal_x_ff <= $signed(csr_wdata);
            REG_GOAL_Y:     goal_y_ff <= $signed(csr_wdata);
            REG_CRUISE:     cruise_ff <= csr_wdata[SPD_W-1:0];
            REG_ARRIVE_TOL: tol_ff    <= csr_wdata[TOL_W-1:0];
         endcase
      end
   end

   // operand helpers
   always_comb begin
      dx_mag   = dx_ff[DELTA_W-1] ? DELTA_W'(-dx_ff) : DELTA_W'(dx_ff);
      dy_mag   = dy_ff[DELTA_W-1] ? DELTA_W'(-dy_ff) : DELTA_W'(dy_ff);
      num      = (22'(diff_ff) <<< 3) - 22'(diff_ff) + (22'(avg0_ff) <<< 1) + 22'(avg0_ff);
      num_mag  = num[21] ? 22'(-num) : 22'(num);
      diff_mag = diff_ff[DELTA_W-1] ? 20'(-diff_ff) : 20'(diff_ff);
      avg_mag  = avg_new_ff[17] ? 20'(-avg_new_ff) : 20'(avg_new_ff);
      n5       = $signed(diff_mag - avg_mag) <<< 1;
      n5_mag   = n5[19] ? 20'(-n5) : 20'(n5);
      v_near   = prod_ff[28:17];
      lin_sel  = far_ff ? cruise_ff : ((v_near > meas_ff) ? v_near : meas_ff);
      ang_sum  = 19'(t5_ff) + 19'(bearing) - 19'(hd_ff);
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_SQX: begin
            mul_a = MUL_W'(dx_mag);
            mul_b = MUL_W'(dx_mag);
         end
         S_SQY: begin
            mul_a = MUL_W'(dy_mag);
            mul_b = MUL_W'(dy_mag);
         end
         S_TOL: begin
            mul_a = MUL_W'(tol_ff);
            mul_b = MUL_W'(tol_ff);
         end
         S_CMP: begin
            mul_a = num_mag[MUL_W-1:0] + MUL_W'(5);
            mul_b = RECIP10;
         end
         S_DIF: begin
            mul_a = MUL_W'(n5_mag) + MUL_W'(2);
            mul_b = RECIP5;
         end
         S_SQRT: begin
            mul_a = MUL_W'(root);
            mul_b = MUL_W'(cruise_ff);
         end
         S_V1: begin
            mul_a = MUL_W'(prod_ff[21:8]);
            mul_b = RECIP3;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      hd_in        = hd_ff;
      meas_in      = meas_ff;
      diff_in      = diff_ff;
      avg0_in      = avg0_ff;
      avg_new_in   = avg_new_ff;
      dsq_in       = dsq_ff;
      far_in       = far_ff;
      arrive_in    = arrive_ff;
      neg_in       = neg_ff;
      t5_in        = t5_ff;
      lin_in       = lin_ff;
      ang_in       = ang_ff;
      prev_ang_in  = prev_ang_ff;
      avg_in       = avg_ff;
      first_in     = first_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_lin_in   = rsp_lin_ff;
      rsp_ang_in   = rsp_ang_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               dx_in    = DELTA_W'(goal_x_ff) - DELTA_W'(req_pos_x);
               dy_in    = DELTA_W'(goal_y_ff) - DELTA_W'(req_pos_y);
               hd_in    = req_heading;
               meas_in  = req_tdata[59:48];
               diff_in  = DELTA_W'(req_heading) - DELTA_W'(prev_ang_ff);
               avg0_in  = first_ff ? 18'(DELTA_W'(req_heading) - DELTA_W'(prev_ang_ff))
                                   : avg_ff;
               state_in = S_SQX;
            end
         end
         S_SQX: state_in = S_SQY;
         S_SQY: begin
            dsq_in   = DSQ_W'(prod_ff);
            state_in = S_TOL;
         end
         S_TOL: begin
            dsq_in   = dsq_ff + DSQ_W'(prod_ff);
            state_in = S_CMP;
         end
         S_CMP: begin
            far_in    = dsq_ff > NEAR_DSQ;
            arrive_in = dsq_ff <= DSQ_W'(prod_ff[29:0]);
            neg_in    = num[21];
            state_in  = S_AVG;
         end
         S_AVG: begin
            avg_new_in = neg_ff ? -$signed(prod_ff[41:24]) : $signed(prod_ff[41:24]);
            state_in   = S_DIF;
         end
         S_DIF: begin
            neg_in   = n5[19];
            state_in = S_DIFW;
         end
         S_DIFW: begin
            t5_in    = neg_ff ? -$signed(prod_ff[37:21]) : $signed(prod_ff[37:21]);
            state_in = S_SQRT;
         end
         S_SQRT: begin
            if (sq_done)
               state_in = S_V1;
         end
         S_V1: state_in = S_V2;
         S_V2: begin
            lin_in   = (lin_sel < MIN_SPEED) ? MIN_SPEED : lin_sel;
            state_in = S_CORW;
         end
         S_CORW: begin
            if (crd_done) begin
               if (ang_sum > 19'sd32767)
                  ang_in = 16'sh7FFF;
               else if (ang_sum < -19'sd32768)
                  ang_in = 16'sh8000;
               else
                  ang_in = ang_sum[ANG_W-1:0];
               state_in = S_OUT1;
            end
         end
         S_OUT1: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_lin_in   = lin_ff;
               rsp_ang_in   = ang_ff;
               rsp_last_in  = 1'b0;
               if (arrive_ff) begin
                  prev_ang_in = '0;
                  avg_in      = '0;
                  first_in    = 1'b1;
                  state_in    = S_OUT2;
               end else begin
                  prev_ang_in = ang_ff;
                  avg_in      = avg_new_ff;
                  first_in    = 1'b0;
                  state_in    = S_IDLE;
               end
            end
         end
         S_OUT2: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_lin_in   = '0;
               rsp_ang_in   = '0;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         prev_ang_ff  <= '0;
         avg_ff       <= '0;
         first_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ang_ff  <= prev_ang_in;
         avg_ff       <= avg_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      hd_ff      <= hd_in;
      meas_ff    <= meas_in;
      diff_ff    <= diff_in;
      avg0_ff    <= avg0_in;
      avg_new_ff <= avg_new_in;
      dsq_ff     <= dsq_in;
      far_ff     <= far_in;
      arrive_ff  <= arrive_in;
      neg_ff     <= neg_in;
      t5_ff      <= t5_in;
      lin_ff     <= lin_in;
      ang_ff     <= ang_in;
      prod_ff    <= mul_a * mul_b;
      rsp_lin_ff <= rsp_lin_in;
      rsp_ang_ff <= rsp_ang_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_ang_ff, rsp_lin_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

[dv/go_to_goal_velocity_controller_checker.sv]
`timescale 1ns / 1ps

module go_to_goal_velocity_controller_checker import ggvc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          cmds_pending
);

   localparam longint NEAR_Q8     = 768;
   localparam longint FLOOR_SPEED = 26;
   localparam longint HALF_TURN   = 205887;

   typedef struct packed {
      logic [SPD_W-1:0] linear;
      logic [ANG_W-1:0] angular;
      logic             last;
   } cmd_type;

   cmd_type expected_cmds[$];
   int     misses = 0;
   longint goal_x, goal_y, cruise, tolerance;
   longint prev_turn, smoothed_diff;
   bit     fresh_start;

   assign fail_count = misses;

   function automatic longint round_div(longint n, longint d);
      if (n >= 0) return (n + d / 2) / d;
      return -((-n + d / 2) / d);
   endfunction

   function automatic longint int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return longint'(r);
   endfunction

   function automatic longint arctan_step(int i);
      case (i)
         0:  return 51472;
         1:  return 30386;
         2:  return 16055;
         3:  return 8150;
         4:  return 4091;
         5:  return 2047;
         6:  return 1024;
         7:  return 512;
         8:  return 256;
         9:  return 128;
         10: return 64;
         11: return 32;
         12: return 16;
         13: return 8;
         14: return 4;
         default: return 2;
      endcase
   endfunction

   // vectoring rotation, angle in Q.16, rounded to Q.12
   function automatic longint bearing_q12(longint dx, longint dy);
      longint x, y, z, nx, ny;
      x = dx * 256;
      y = dy * 256;
      z = 0;
      if (dx == 0 && dy == 0) return 0;
      if (dx < 0) begin
         x = -x;
         y = -y;
         z = (dy >= 0) ? HALF_TURN : -HALF_TURN;
      end
      for (int i = 0; i < 16; i++) begin
         if (y >= 0) begin
            nx = x + (y >>> i);
            ny = y - (x >>> i);
            z  = z + arctan_step(i);
         end else begin
            nx = x - (y >>> i);
            ny = y + (x >>> i);
            z  = z - arctan_step(i);
         end
         x = nx;
         y = ny;
      end
      return round_div(z, 16);
   endfunction

   function automatic void restart_heading();
      prev_turn     = 0;
      smoothed_diff = 0;
      fresh_start   = 1'b1;
   endfunction

   function automatic void predict_tick(logic [63:0] data);
      longint px, py, hd, meas, dx, dy, dsq, lin, diff, avg, turn, v;
      cmd_type c;
      px   = longint'($signed(data[15:0]));
      py   = longint'($signed(data[31:16]));
      hd   = longint'($signed(data[47:32]));
      meas = longint'(data[59:48]);
      dx   = goal_x - px;
      dy   = goal_y - py;
      dsq  = dx * dx + dy * dy;
      if (dsq > NEAR_Q8 * NEAR_Q8) begin
         lin = cruise;
      end else begin
         v   = int_sqrt(dsq) * cruise / NEAR_Q8;
         lin = (v > meas) ? v : meas;
      end
      if (lin < FLOOR_SPEED) lin = FLOOR_SPEED;

      diff = hd - prev_turn;
      avg  = fresh_start ? diff : smoothed_diff;
      avg  = round_div(7 * diff + 3 * avg, 10);
      turn = round_div(2 * ((diff < 0 ? -diff : diff) - (avg < 0 ? -avg : avg)), 5)
             + bearing_q12(dx, dy) - hd;
      if (turn > 32767)  turn = 32767;
      if (turn < -32768) turn = -32768;
      prev_turn     = turn;
      smoothed_diff = avg;
      fresh_start   = 1'b0;

      c.linear  = lin[SPD_W-1:0];
      c.angular = turn[ANG_W-1:0];
      c.last    = 1'b0;
      expected_cmds.push_back(c);

      if (dsq <= tolerance * tolerance) begin
         c = '0;
         c.last = 1'b1;
         expected_cmds.push_back(c);
         restart_heading();
      end
   endfunction

   always @(posedge clock) begin
      cmd_type want, seen;
      if (reset) begin
         goal_x    = 256;
         goal_y    = 256;
         cruise    = 256;
         tolerance = 3;
         restart_heading();
         expected_cmds.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_GOAL_X:     goal_x    = longint'($signed(csr_wdata));
               REG_GOAL_Y:     goal_y    = longint'($signed(csr_wdata));
               REG_CRUISE:     cruise    = longint'(csr_wdata[SPD_W-1:0]);
               REG_ARRIVE_TOL: tolerance = longint'(csr_wdata[TOL_W-1:0]);
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            seen.linear  = rsp_tdata[11:0];
            seen.angular = rsp_tdata[27:12];
            seen.last    = rsp_tlast;
            if (expected_cmds.size() == 0) begin
               misses++;
               if (misses <= 10)
                  $display("unexpected command: linear %0d angular %0d last %0b",
                           seen.linear, $signed(seen.angular), seen.last);
            end else begin
               want = expected_cmds.pop_front();
               if (want.linear !== seen.linear || want.angular !== seen.angular ||
                   want.last !== seen.last) begin
                  misses++;
                  if (misses <= 10)
                     $display({"command mismatch: linear exp %0d got %0d, ",
                               "angular exp %0d got %0d, last exp %0b got %0b"},
                              want.linear, seen.linear, $signed(want.angular),
                              $signed(seen.angular), want.last, seen.last);
               end
            end
         end
         if (req_tvalid && req_tready) predict_tick(req_tdata);
      end
      cmds_pending <= expected_cmds.size();
   end

endmodule

[dv/go_to_goal_velocity_controller_core_tb.sv]
`timescale 1ns / 1ps

module go_to_goal_velocity_controller_core_tb import ggvc_pkg::*;;

   localparam int NEAR_Q8     = 768;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int PHASES      = 12;
   localparam int PHASE_TICKS = 160;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   int fail_count;
   int cmds_pending;
   int cycle_count = 0;
   int stall_left = 0;
   bit calm = 1'b0;
   int goal_x_set = 256, goal_y_set = 256, tol_set = 3;

   go_to_goal_velocity_controller_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   go_to_goal_velocity_controller_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .fail_count   (fail_count),
      .cmds_pending (cmds_pending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // mostly short gaps, the odd long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (calm)   return 0;
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 4);
      if (r < 97) return $urandom_range(5, 20);
      return $urandom_range(30, 80);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         stall_left <= ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      end
   end

   function automatic int clamp16(int v);
      if (v > 32767)  return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // valid is left high after the transaction; the next call or drain decides
   task automatic send_tick(int px, int py, int hd, int meas);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, meas[11:0], hd[15:0], py[15:0], px[15:0]};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain(int tail);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (cmds_pending != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic program_regs(int gx, int gy, int cruise, int tol);
      csr_we    <= 1'b1;
      csr_index <= REG_GOAL_X;
      csr_wdata <= gx[15:0];
      @(posedge clock);
      csr_index <= REG_GOAL_Y;
      csr_wdata <= gy[15:0];
      @(posedge clock);
      csr_index <= REG_CRUISE;
      csr_wdata <= 16'(cruise);
      @(posedge clock);
      csr_index <= REG_ARRIVE_TOL;
      csr_wdata <= 16'(tol);
      @(posedge clock);
      csr_we <= 1'b0;
      goal_x_set = gx;
      goal_y_set = gy;
      tol_set    = tol;
   endtask

   task automatic random_tick();
      int r, ox, oy, span, hd, meas, tmp;
      r    = $urandom_range(0, 99);
      hd   = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 32768) - 16384
                                           : $urandom_range(0, 65535) - 32768;
      meas = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 600);
      if (r < 15) begin
         send_tick($urandom, $urandom, $urandom, $urandom_range(0, 4095));
      end else begin
         if (r < 35) begin
            // inside the arrival circle
            span = tol_set * 7 / 10;
            if (span > 20000) span = 20000;
            ox = $urandom_range(0, 2 * span) - span;
            oy = $urandom_range(0, 2 * span) - span;
         end else if (r < 45) begin
            // on the tolerance ring or the 3 m boundary
            case ($urandom_range(0, 3))
               0: ox = tol_set;
               1: ox = tol_set + 1;
               2: ox = NEAR_Q8;
               default: ox = NEAR_Q8 + 1;
            endcase
            oy = 0;
            if ($urandom_range(0, 1)) ox = -ox;
            if ($urandom_range(0, 1)) begin
               tmp = ox;
               ox  = oy;
               oy  = tmp;
            end
         end else begin
            case ($urandom_range(0, 2))
               0: span = 256;
               1: span = 1000;
               default: span = 5000;
            endcase
            ox = $urandom_range(0, 2 * span) - span;
            oy = $urandom_range(0, 2 * span) - span;
         end
         send_tick(clamp16(goal_x_set - ox), clamp16(goal_y_set - oy), hd, meas);
      end
   endtask

   initial begin
      int gx, gy, cruise, tol, r;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults: goal (1 m, 1 m), cruise 1 m/s, tolerance 3
      send_tick(256, 256, 0, 0);
      send_tick(256, 256, 32767, 4095);
      send_tick(-32768, -32768, -32768, 0);
      send_tick(32767, 32767, 32767, 4095);
      send_tick(32767, -32768, 0, 0);
      send_tick(1000, 256, -32768, 0);
      send_tick(256, 1000, 32767, 0);
      send_tick(256 - NEAR_Q8, 256, 0, 100);
      send_tick(256 - NEAR_Q8 - 1, 256, 0, 100);
      send_tick(253, 256, 500, 7);
      send_tick(253, 255, -500, 7);
      send_tick(156, 256, 0, 4095);
      send_tick(246, 256, 0, 0);
      drain(8);

      program_regs(-32768, 32767, 0, 0);
      send_tick(-32768, 32767, 0, 0);
      send_tick(0, 0, 1234, 0);
      send_tick(-32767, 32767, 0, 0);
      drain(8);

      program_regs(32767, -32768, 4095, 32767);
      send_tick(-32768, 32767, 0, 0);
      send_tick(0, 0, -20000, 0);
      send_tick(20000, -20000, 5000, 0);
      send_tick(32267, -32468, 0, 2000);
      drain(8);

      for (int ph = 0; ph < PHASES; ph++) begin
         calm = (ph % 4 == 3);
         r  = $urandom_range(0, 99);
         gx = (r < 15) ? -32768 : (r < 30) ? 32767 : $urandom_range(0, 16000) - 8000;
         r  = $urandom_range(0, 99);
         gy = (r < 15) ? 32767 : (r < 30) ? -32768 : $urandom_range(0, 16000) - 8000;
         r  = $urandom_range(0, 99);
         cruise = (r < 20) ? 0 : (r < 40) ? 4095 : $urandom_range(0, 4095);
         r  = $urandom_range(0, 99);
         tol = (r < 10) ? 0 : (r < 20) ? 32767 :
               (r < 60) ? $urandom_range(0, 60) : $urandom_range(0, 1500);
         program_regs(gx, gy, cruise, tol);
         repeat (PHASE_TICKS) random_tick();
         drain(8);
      end

      calm = 1'b0;
      drain(24);
      @(negedge clock);
      if (fail_count == 0 && cmds_pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
